// ----- hw/rtl/sac_pkg.sv -----
// sac_pkg: shared constants, codes and the result record of the byte cache
// depends on nothing; used by sac_out_reg and the top level
package sac_pkg;

    localparam int DEF_SETS       = 64;
    localparam int DEF_WAYS       = 4;
    localparam int DEF_LINE_BYTES = 16;
    localparam int DEF_ADDR_BITS  = 32;

    localparam int WORD_W = 32;
    localparam int BYTE_W = 8;

    // input op codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_DONE = 2'd0;
    localparam logic [1:0] KIND_WB   = 2'd1;
    localparam logic [1:0] KIND_REQ  = 2'd2;
    localparam logic [1:0] KIND_WT   = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic              hit;
        logic [BYTE_W-1:0] read_byte;
        logic [WORD_W-1:0] mem_addr;
        logic [WORD_W-1:0] mem_word;
        logic              last;
    } result_t;

    function automatic int floor_log2(input int n);
        int c;
        int v;
        c = 0;
        v = n;
        while (v > 1) begin
            v = v >> 1;
            c = c + 1;
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/sac_ram.sv -----
// sac_ram: generic single-write, single-read memory with registered read data
// depends on nothing
module sac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/sac_out_reg.sv -----
// sac_out_reg: output holding register between the cache sequencer and the result stream
// depends on sac_pkg (result_t)
module sac_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sac_pkg::result_t din,
    input  logic             ready,
    output logic             valid,
    output sac_pkg::result_t dout,
    output logic             free
);

    import sac_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign free  = !valid_reg || ready;
    assign valid = valid_reg;
    assign dout  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

endmodule

// ----- hw/rtl/set_assoc_lru_byte_cache_unit.sv -----
// set_assoc_lru_byte_cache_unit: set-associative lru byte cache, write-allocate,
// write-back or write-through; depends on sac_pkg, sac_ram and sac_out_reg
//
// channel     dir  handshake                 payload
// s_axis      in   tvalid/tready             tuser op, tdata addr/byte/fill word
// m_axis      out  tvalid/tready, tlast      tuser kind, tdata hit/byte/addr/word
// cfg         in   cfg_wr_en                 cfg_wr_data write_back_mode
//
// a hit read steps through tag row read, hit compare with data word read, byte select
// and result load; the result then waits in the output register until taken
// a hit write takes the same steps, the merged word is stored in the byte select
// step; write-through adds a data read and a beat output per line word
// a miss scans one way per cycle for the victim, then for a dirty victim a data read
// and a beat output per writeback beat; every line word beat is one read of the data memory port
// each fill word is stored as it is accepted; the last one adds a tag row update and completion
// reset clears valid and dirty bits, stamps counter and the pending access at once;
// a stalled result stream holds the sequencer before its next result only
module set_assoc_lru_byte_cache_unit #(
    parameter int SETS       = sac_pkg::DEF_SETS,
    parameter int WAYS       = sac_pkg::DEF_WAYS,
    parameter int LINE_BYTES = sac_pkg::DEF_LINE_BYTES,
    parameter int ADDR_BITS  = sac_pkg::DEF_ADDR_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side: tuser = op[1:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata = byte_addr[31:0], write_byte[39:32], fill_word[71:40]
    input  logic [71:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    // master side: tuser = kind[1:0], tlast = last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata = hit[0], read_byte[8:1], mem_addr[40:9], mem_word[72:41], zeros above
    output logic [79:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    // write_back_mode register
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);

    import sac_pkg::*;

    localparam int OB       = floor_log2(LINE_BYTES);
    localparam int IB       = floor_log2(SETS);
    localparam int TAGW     = ADDR_BITS - OB - IB;
    localparam int WPL      = 1 << (OB - 2);
    localparam int NLINES   = SETS * WAYS;
    localparam int NWORDS   = NLINES * WPL;
    localparam int LW       = NLINES > 1 ? $clog2(NLINES) : 1;
    localparam int DAW      = NWORDS > 1 ? $clog2(NWORDS) : 1;
    localparam int SAW      = SETS > 1 ? $clog2(SETS) : 1;
    localparam int WW       = WAYS > 1 ? $clog2(WAYS) : 1;
    localparam int CW       = OB > 2 ? OB - 2 : 1;
    localparam int ENT_W    = TAGW + WORD_W;
    localparam int ROW_W    = WAYS * ENT_W;
    localparam int SET_MASK = (1 << IB) - 1;

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LOOK    = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_FILLROW = 4'd3;
    localparam logic [3:0] S_WORD    = 4'd4;
    localparam logic [3:0] S_BRD     = 4'd5;
    localparam logic [3:0] S_BOUT    = 4'd6;
    localparam logic [3:0] S_DONE    = 4'd7;
    localparam logic [3:0] S_REQ     = 4'd8;

    // address helpers
    function automatic logic [SAW-1:0] set_of(input logic [ADDR_BITS-1:0] a);
        return SAW'((a >> OB) & ADDR_BITS'(SET_MASK));
    endfunction

    function automatic logic [TAGW-1:0] tag_of(input logic [ADDR_BITS-1:0] a);
        return TAGW'(a >> (OB + IB));
    endfunction

    function automatic logic [LW-1:0] line_of(input logic [SAW-1:0] s,
                                              input logic [WW-1:0] w);
        return LW'(s) * LW'(WAYS) + LW'(w);
    endfunction

    function automatic logic [DAW-1:0] word_of(input logic [LW-1:0] ln,
                                               input logic [CW-1:0] wi);
        return DAW'(ln) * DAW'(WPL) + DAW'(wi);
    endfunction

    // registers
    logic [3:0]           state_reg, state_next;
    logic                 op_wr_reg, op_wr_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic [WW-1:0]        way_reg, way_next;
    logic                 hit_reg, hit_next;
    logic                 pend_reg, pend_next;
    logic [CW-1:0]        fill_cnt_reg, fill_cnt_next;
    logic [CW-1:0]        beat_cnt_reg, beat_cnt_next;
    logic [1:0]           beat_kind_reg, beat_kind_next;
    logic [ADDR_BITS-1:0] beat_addr_reg, beat_addr_next;
    logic [BYTE_W-1:0]    rbyte_reg, rbyte_next;
    logic [WW-1:0]        scan_cnt_reg, scan_cnt_next;
    logic [WORD_W-1:0]    best_reg, best_next;
    logic [WORD_W-1:0]    stamp_reg, stamp_next;
    logic                 wb_mode_reg;
    logic [NLINES-1:0]    valid_reg, valid_next;
    logic [NLINES-1:0]    dirty_reg, dirty_next;

    // memory ports
    logic             tag_we, tag_re;
    logic [SAW-1:0]   tag_waddr, tag_raddr;
    logic [ROW_W-1:0] tag_wdata, tag_rd;
    logic             dat_we, dat_re;
    logic [DAW-1:0]   dat_waddr, dat_raddr;
    logic [WORD_W-1:0] dat_wdata, dat_rd;

    // result stage
    logic    emit, out_free;
    result_t emit_data, out_data;

    // input fields
    logic [1:0]           in_op;
    logic [ADDR_BITS-1:0] in_addr;
    logic [BYTE_W-1:0]    in_byte;
    logic [WORD_W-1:0]    in_fill;
    logic                 in_fire;

    assign in_op   = s_axis_tuser;
    assign in_addr = ADDR_BITS'(s_axis_tdata[31:0]);
    assign in_byte = s_axis_tdata[39:32];
    assign in_fill = s_axis_tdata[71:40];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // decoded fields of the current access
    logic [SAW-1:0]       cur_set;
    logic [TAGW-1:0]      cur_tag;
    logic [LW-1:0]        cur_line;
    logic [CW-1:0]        cur_widx;
    logic [ADDR_BITS-1:0] cur_line_addr;

    assign cur_set       = set_of(addr_reg);
    assign cur_tag       = tag_of(addr_reg);
    assign cur_line      = line_of(cur_set, way_reg);
    assign cur_widx      = CW'(addr_reg[OB-1:0] >> 2);
    assign cur_line_addr = (addr_reg >> OB) << OB;

    // hit compare across the ways of the row just read, lowest way wins
    logic          hit_any;
    logic [WW-1:0] hit_way;

    always_comb
    begin
        hit_any = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (valid_reg[line_of(cur_set, WW'(w))] &&
                tag_rd[w*ENT_W +: TAGW] == cur_tag)
            begin
                hit_any = 1'b1;
                hit_way = WW'(w);
            end
        end
    end

    // row with one way's tag and stamp replaced
    logic [WW-1:0]     upd_way;
    logic [WORD_W-1:0] new_stamp;
    logic [ROW_W-1:0]  row_upd;

    assign new_stamp = stamp_reg + 32'd1;

    always_comb
    begin
        row_upd = tag_rd;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WW'(w) == upd_way)
            begin
                row_upd[w*ENT_W +: ENT_W] = {new_stamp, cur_tag};
            end
        end
    end

    // victim scan, one way per cycle
    logic [LW-1:0]     scan_line;
    logic [WORD_W-1:0] scan_stamp;
    logic [TAGW-1:0]   vict_tag;
    logic [LW-1:0]     vict_line;

    assign scan_line  = line_of(cur_set, scan_cnt_reg);
    assign scan_stamp = tag_rd[scan_cnt_reg*ENT_W + TAGW +: WORD_W];

    // merged byte for a write
    logic [WORD_W-1:0] merged;

    always_comb
    begin
        merged = dat_rd;
        merged[addr_reg[1:0]*BYTE_W +: BYTE_W] = byte_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_wr_next     = op_wr_reg;
        addr_next      = addr_reg;
        byte_next      = byte_reg;
        way_next       = way_reg;
        hit_next       = hit_reg;
        pend_next      = pend_reg;
        fill_cnt_next  = fill_cnt_reg;
        beat_cnt_next  = beat_cnt_reg;
        beat_kind_next = beat_kind_reg;
        beat_addr_next = beat_addr_reg;
        rbyte_next     = rbyte_reg;
        scan_cnt_next  = scan_cnt_reg;
        best_next      = best_reg;
        stamp_next     = stamp_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;

        tag_we    = 1'b0;
        tag_re    = 1'b0;
        tag_waddr = cur_set;
        tag_raddr = cur_set;
        tag_wdata = row_upd;
        upd_way   = way_reg;
        dat_we    = 1'b0;
        dat_re    = 1'b0;
        dat_waddr = word_of(cur_line, cur_widx);
        dat_raddr = word_of(cur_line, cur_widx);
        dat_wdata = merged;
        vict_tag  = '0;
        vict_line = '0;

        emit      = 1'b0;
        emit_data = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_op == OP_FILL)
                    begin
                        if (pend_reg)
                        begin
                            // store the beat in the victim line
                            dat_we    = 1'b1;
                            dat_waddr = word_of(cur_line, fill_cnt_reg);
                            dat_wdata = in_fill;
                            if (fill_cnt_reg == CW'(WPL - 1))
                            begin
                                fill_cnt_next = '0;
                                pend_next     = 1'b0;
                                tag_re        = 1'b1;
                                state_next    = S_FILLROW;
                            end
                            else
                            begin
                                fill_cnt_next = fill_cnt_reg + CW'(1);
                            end
                        end
                    end
                    else if ((in_op == OP_READ || in_op == OP_WRITE) && !pend_reg)
                    begin
                        addr_next  = in_addr;
                        op_wr_next = (in_op == OP_WRITE);
                        byte_next  = in_byte;
                        tag_re     = 1'b1;
                        tag_raddr  = set_of(in_addr);
                        state_next = S_LOOK;
                    end
                end
            end

            S_LOOK:
            begin
                if (hit_any)
                begin
                    upd_way    = hit_way;
                    tag_we     = 1'b1;
                    stamp_next = new_stamp;
                    way_next   = hit_way;
                    hit_next   = 1'b1;
                    dat_re     = 1'b1;
                    dat_raddr  = word_of(line_of(cur_set, hit_way), cur_widx);
                    state_next = S_WORD;
                end
                else
                begin
                    scan_cnt_next = '0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (!valid_reg[scan_line])
                begin
                    way_next = scan_cnt_reg;
                end
                else if (scan_cnt_reg == '0 || scan_stamp < best_reg)
                begin
                    best_next = scan_stamp;
                    way_next  = scan_cnt_reg;
                end
                if (!valid_reg[scan_line] || scan_cnt_reg == WW'(WAYS - 1))
                begin
                    vict_line = line_of(cur_set, way_next);
                    vict_tag  = tag_rd[way_next*ENT_W +: TAGW];
                    if (valid_reg[vict_line] && dirty_reg[vict_line])
                    begin
                        beat_kind_next = KIND_WB;
                        beat_cnt_next  = '0;
                        beat_addr_next = (ADDR_BITS'(vict_tag) << (OB + IB)) |
                                         (ADDR_BITS'(cur_set) << OB);
                        state_next     = S_BRD;
                    end
                    else
                    begin
                        state_next = S_REQ;
                    end
                    valid_next[vict_line] = 1'b0;
                    dirty_next[vict_line] = 1'b0;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + WW'(1);
                end
            end

            S_FILLROW:
            begin
                tag_we               = 1'b1;
                stamp_next           = new_stamp;
                valid_next[cur_line] = 1'b1;
                dirty_next[cur_line] = 1'b0;
                hit_next             = 1'b0;
                dat_re               = 1'b1;
                state_next           = S_WORD;
            end

            S_WORD:
            begin
                if (op_wr_reg)
                begin
                    dat_we     = 1'b1;
                    rbyte_next = '0;
                    if (wb_mode_reg)
                    begin
                        dirty_next[cur_line] = 1'b1;
                        state_next           = S_DONE;
                    end
                    else
                    begin
                        dirty_next[cur_line] = 1'b0;
                        beat_kind_next       = KIND_WT;
                        beat_cnt_next        = '0;
                        beat_addr_next       = cur_line_addr;
                        state_next           = S_BRD;
                    end
                end
                else
                begin
                    rbyte_next = dat_rd[addr_reg[1:0]*BYTE_W +: BYTE_W];
                    state_next = S_DONE;
                end
            end

            S_BRD:
            begin
                dat_re     = 1'b1;
                dat_raddr  = word_of(cur_line, beat_cnt_reg);
                state_next = S_BOUT;
            end

            S_BOUT:
            begin
                if (out_free)
                begin
                    emit               = 1'b1;
                    emit_data.kind     = beat_kind_reg;
                    emit_data.mem_addr = WORD_W'(beat_addr_reg);
                    emit_data.mem_word = dat_rd;
                    if (beat_cnt_reg == CW'(WPL - 1))
                    begin
                        state_next = (beat_kind_reg == KIND_WB) ? S_REQ : S_DONE;
                    end
                    else
                    begin
                        beat_cnt_next = beat_cnt_reg + CW'(1);
                        state_next    = S_BRD;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    emit                = 1'b1;
                    emit_data.kind      = KIND_DONE;
                    emit_data.hit       = hit_reg;
                    emit_data.read_byte = rbyte_reg;
                    emit_data.last      = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            S_REQ:
            begin
                if (out_free)
                begin
                    emit               = 1'b1;
                    emit_data.kind     = KIND_REQ;
                    emit_data.mem_addr = WORD_W'(cur_line_addr);
                    emit_data.last     = 1'b1;
                    pend_next          = 1'b1;
                    fill_cnt_next      = '0;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pend_reg     <= 1'b0;
            fill_cnt_reg <= '0;
            stamp_reg    <= '0;
            wb_mode_reg  <= 1'b1;
            valid_reg    <= '0;
            dirty_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            fill_cnt_reg <= fill_cnt_next;
            stamp_reg    <= stamp_next;
            valid_reg    <= valid_next;
            dirty_reg    <= dirty_next;
            if (cfg_wr_en)
            begin
                wb_mode_reg <= cfg_wr_data;
            end
        end
    end

    // access context and beat bookkeeping
    always_ff @(posedge clk)
    begin
        op_wr_reg     <= op_wr_next;
        addr_reg      <= addr_next;
        byte_reg      <= byte_next;
        way_reg       <= way_next;
        hit_reg       <= hit_next;
        beat_cnt_reg  <= beat_cnt_next;
        beat_kind_reg <= beat_kind_next;
        beat_addr_reg <= beat_addr_next;
        rbyte_reg     <= rbyte_next;
        scan_cnt_reg  <= scan_cnt_next;
        best_reg      <= best_next;
    end

    // one row per set: per way {stamp, tag}
    sac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (tag_re),
        .raddr (tag_raddr),
        .rdata (tag_rd)
    );

    // line data, one word per entry
    sac_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS)
    ) u_data_ram (
        .clk   (clk),
        .we    (dat_we),
        .waddr (dat_waddr),
        .wdata (dat_wdata),
        .re    (dat_re),
        .raddr (dat_raddr),
        .rdata (dat_rd)
    );

    sac_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (emit),
        .din   (emit_data),
        .ready (m_axis_tready),
        .valid (m_axis_tvalid),
        .dout  (out_data),
        .free  (out_free)
    );

    assign m_axis_tuser = out_data.kind;
    assign m_axis_tlast = out_data.last;
    assign m_axis_tdata = {7'd0, out_data.mem_word, out_data.mem_addr,
                           out_data.read_byte, out_data.hit};

`ifndef SYNTHESIS
    // an access arriving while a miss waits for its line is dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && pend_reg && in_op != OP_FILL |=> state_reg == S_IDLE)
        else $error("access during pending miss was not dropped");

    // stamps advance by at most one per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        stamp_reg == $past(stamp_reg) || stamp_reg == $past(stamp_reg) + 32'd1)
        else $error("stamp counter jumped");

    // a result is only loaded into a free output stage
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result overwrote a waiting transaction");

    // a fill request leaves a miss pending
    assert property (@(posedge clk) disable iff (!rst_n)
        emit && emit_data.kind == KIND_REQ |=> pend_reg)
        else $error("fill request without pending miss");
`endif

endmodule
